FILE: hdl/tctp_pkg.sv
// shared types, widths and codes of the threshold crossing time unit
package tctp_pkg;

  // field widths fixed by the interface
  localparam int SMP_W   = 16;
  localparam int TIN_W   = 32;
  localparam int TIME_W  = 41;
  localparam int IDX_W   = 10;
  localparam int STAT_W  = 2;
  localparam int PER_W   = 16;

  // waveform length limit and fixed point of the fractional index
  localparam int MAX_SAMPLES = 1024;
  localparam int FRAC_BITS   = 8;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // fit arithmetic widths
  localparam int DIF_W  = SMP_W + 1;
  localparam int T3_W   = SMP_W + 3;
  localparam int DEN_W  = 2 * DIF_W;
  localparam int MA_W   = DEN_W + 1;
  localparam int MB_W   = T3_W;
  localparam int ACC_W  = DEN_W + IDX_W + 2;
  localparam int NUM_W  = ACC_W + FRAC_BITS;
  localparam int PW     = TIME_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam int SCNT_W = $clog2(PER_W);

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_PERIOD    = 1'b1;
  localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(1000);

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_CROSS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_AT_FIRST = 2'd2;
  localparam logic [STAT_W-1:0] STAT_AT_LAST  = 2'd3;

  // crossing search progress within one waveform
  typedef enum logic [1:0] {
    PH_SEARCH     = 2'd0,
    PH_NEED_AFTER = 2'd1,
    PH_READY      = 2'd2,
    PH_AT_FIRST   = 2'd3
  } phase_t;

  // controller states
  typedef enum logic [3:0] {
    S_COLLECT,
    S_EVAL,
    S_DIFF,
    S_SQ0,
    S_SQ1,
    S_SQ2,
    S_XP,
    S_IDX,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SCL_GO,
    S_SCL_WAIT,
    S_EMIT
  } state_t;

  // operand pair of the shared multiplier
  typedef enum logic [2:0] {
    MUL_SQ01,
    MUL_SQ12,
    MUL_SQ02,
    MUL_XP,
    MUL_IDX
  } mul_sel_t;

  // accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic     sample_en;
    logic     diff_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     den_load;
    logic     div_start;
    logic     scl_start;
    logic     out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    phase_t phase;
    logic   div_done;
    logic   scl_done;
  } dp_sts_t;

endpackage

FILE: hdl/threshold_crossing_time_interp_unit.sv
// top level: configuration registers, stream packing and unit instances
//
// Takes one waveform sample per transaction and, on the transaction with
// tlast, returns one result: the interpolated threshold crossing time, the
// index of the first sample above threshold and a status code. Samples are
// taken at one per cycle while a waveform is collected. After tlast the
// input stalls while the result is formed: through the evaluate and emit
// states when there is no fit (no crossing, crossing on the first or the
// last sample), otherwise also through the fit steps, the one-bit-per-cycle
// divider and the shift-add period scaling.
// The next waveform may start while the finished result waits on out_tready;
// a further result waits in the emit state until the output is free.
// Configuration is to be written by the user only while no waveform is in flight; the block does not enforce it.
module threshold_crossing_time_interp_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: sample [15:0], start_time_ps [47:16]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [47:0]                        in_tdata,
  input  logic                               in_tlast,
  // out_tdata: crossing_time_ps [40:0], crossing_index [50:41], status [52:51]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [55:0]                        out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tctp_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [tctp_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [tctp_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);
  import tctp_pkg::*;

  logic signed [SMP_W-1:0] threshold_r;
  logic [PER_W-1:0]        period_r;
  logic                    cfg_wr;
  logic                    reg_sel;

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  logic [TIME_W-1:0]       res_time;
  logic [IDX_W-1:0]        res_index;
  logic [STAT_W-1:0]       res_status;

  // configuration write and read
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      period_r    <= PERIOD_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_THRESHOLD: threshold_r <= cfg_pwdata[SMP_W-1:0];
        REG_PERIOD:    period_r    <= cfg_pwdata[PER_W-1:0];
        default:       period_r    <= period_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: cfg_prdata = CFG_DW'(threshold_r);
      REG_PERIOD:    cfg_prdata = CFG_DW'(period_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // controller
  tctp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath
  tctp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .threshold     (threshold_r),
    .sample_period (period_r),
    .in_sample     ($signed(in_tdata[SMP_W-1:0])),
    .in_start_time (in_tdata[SMP_W+TIN_W-1:SMP_W]),
    .cmd           (cmd),
    .sts           (sts),
    .out_time      (res_time),
    .out_index     (res_index),
    .out_status    (res_status)
  );

  // result packing, padded to whole bytes
  assign out_tdata = {3'b000, res_status, res_index, res_time};

endmodule

FILE: hdl/tctp_div.sv
// bit-serial signed by unsigned divider, quotient rounded toward zero
module tctp_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [tctp_pkg::NUM_W-1:0]  num,
  input  logic        [tctp_pkg::DEN_W-1:0]  den,
  output logic                               done,
  output logic signed [tctp_pkg::NUM_W-1:0]  quo
);
  import tctp_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [NUM_W-1:0]  dvd_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic              neg_r;

  logic [NUM_W-1:0]  mag;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic [DEN_W:0]    diff;
  logic [DEN_W-1:0]  rem_nxt;

  // magnitude of the dividend
  assign mag = num[NUM_W-1] ? (~num + 1'b1) : num;

  // one restoring step per cycle
  assign trial   = {rem_r, dvd_r[NUM_W-1]};
  assign ge      = (trial >= {1'b0, den_r});
  assign diff    = trial - {1'b0, den_r};
  assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= mag;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? $signed(~dvd_r + 1'b1) : $signed(dvd_r);

endmodule

FILE: hdl/tctp_dp.sv
// datapath: crossing capture, fit arithmetic, time scaling and result register
module tctp_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [tctp_pkg::SMP_W-1:0]  threshold,
  input  logic        [tctp_pkg::PER_W-1:0]  sample_period,
  input  logic signed [tctp_pkg::SMP_W-1:0]  in_sample,
  input  logic        [tctp_pkg::TIN_W-1:0]  in_start_time,
  input  tctp_pkg::dp_cmd_t                  cmd,
  output tctp_pkg::dp_sts_t                  sts,
  output logic        [tctp_pkg::TIME_W-1:0] out_time,
  output logic        [tctp_pkg::IDX_W-1:0]  out_index,
  output logic        [tctp_pkg::STAT_W-1:0] out_status
);
  import tctp_pkg::*;

  // capture state
  phase_t                   phase_r, phase_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [SMP_W-1:0]  prev_r, a0_r, a1_r, a2_r;
  logic [IDX_W-1:0]         cpos_r;
  logic [TIN_W-1:0]         start_r;
  logic                     in_range;

  // fit registers
  logic signed [DIF_W-1:0]  d01_r, d12_r, d02_r, ad_r;
  logic signed [T3_W-1:0]   t3_r;
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [MA_W+MB_W-1:0] prod_full;
  logic signed [ACC_W-1:0]  prod_r, acc_r;
  logic [DEN_W-1:0]         den_r;

  // divider and scaler
  logic signed [NUM_W-1:0]  div_num;
  logic signed [NUM_W-1:0]  quo;
  logic                     div_done;
  logic [PW-1:0]            mc_r, p_r;
  logic [PER_W-1:0]         per_r;
  logic [SCNT_W-1:0]        scl_cnt_r;
  logic                     scl_busy_r, scl_done_r;

  // result register
  logic [TIME_W-1:0]        time_r;
  logic [IDX_W-1:0]         index_r;
  logic [STAT_W-1:0]        status_r;
  logic [TIME_W-1:0]        fit_time;

  assign in_range = (cnt_r < CNT_W'(MAX_SAMPLES));

  // search progress and sample count, cleared when the result is taken over
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (cmd.sample_en && in_range) begin
      cnt_nxt = cnt_r + 1'b1;
      case (phase_r)
        PH_SEARCH: begin
          if (in_sample > threshold) begin
            phase_nxt = (cnt_r == '0) ? PH_AT_FIRST : PH_NEED_AFTER;
          end
        end
        PH_NEED_AFTER: phase_nxt = PH_READY;
        default:       phase_nxt = phase_r;
      endcase
    end
    if (cmd.out_load) begin
      phase_nxt = PH_SEARCH;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // amplitudes around the crossing
  always_ff @(posedge clk) begin
    if (cmd.sample_en && in_range) begin
      prev_r <= in_sample;
      if (cnt_r == '0) begin
        start_r <= in_start_time;
      end
      if (phase_r == PH_SEARCH && in_sample > threshold) begin
        a1_r   <= in_sample;
        a0_r   <= prev_r;
        cpos_r <= cnt_r[IDX_W-1:0];
      end
      if (phase_r == PH_NEED_AFTER) begin
        a2_r <= in_sample;
      end
    end
  end

  // pairwise differences and the threshold term
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      d01_r <= DIF_W'(a0_r) - DIF_W'(a1_r);
      d12_r <= DIF_W'(a1_r) - DIF_W'(a2_r);
      d02_r <= DIF_W'(a0_r) - DIF_W'(a2_r);
      ad_r  <= DIF_W'(a2_r) - DIF_W'(a0_r);
      t3_r  <= T3_W'(threshold) + T3_W'(threshold) + T3_W'(threshold)
               - T3_W'(a0_r) - T3_W'(a1_r) - T3_W'(a2_r);
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_SQ01: begin
        ma = MA_W'(d01_r);
        mb = MB_W'(d01_r);
      end
      MUL_SQ12: begin
        ma = MA_W'(d12_r);
        mb = MB_W'(d12_r);
      end
      MUL_SQ02: begin
        ma = MA_W'(d02_r);
        mb = MB_W'(d02_r);
      end
      MUL_XP: begin
        ma = MA_W'(ad_r);
        mb = t3_r;
      end
      MUL_IDX: begin
        ma = $signed({1'b0, acc_r[DEN_W-1:0]});
        mb = $signed(MB_W'(cpos_r));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_full = ma * mb;

  // product register, accumulator and denominator
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_full[ACC_W-1:0];
    end
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= prod_r;
      ACC_ADD:  acc_r <= acc_r + prod_r;
      default:  acc_r <= acc_r;
    endcase
    if (cmd.den_load) begin
      den_r <= acc_r[DEN_W-1:0];
    end
  end

  // fractional index: numerator in fixed point over the denominator
  assign div_num = $signed({acc_r, {FRAC_BITS{1'b0}}});

  tctp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  // shift-add scaling by the sample period, kept modulo the result width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_busy_r <= 1'b0;
      scl_done_r <= 1'b0;
      scl_cnt_r  <= '0;
    end else begin
      scl_done_r <= 1'b0;
      if (cmd.scl_start) begin
        scl_busy_r <= 1'b1;
        scl_cnt_r  <= '0;
      end else if (scl_busy_r) begin
        scl_cnt_r <= scl_cnt_r + 1'b1;
        if (scl_cnt_r == SCNT_W'(PER_W - 1)) begin
          scl_busy_r <= 1'b0;
          scl_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scl_start) begin
      mc_r  <= quo[PW-1:0];
      per_r <= sample_period;
      p_r   <= '0;
    end else if (scl_busy_r) begin
      if (per_r[0]) begin
        p_r <= p_r + mc_r;
      end
      mc_r  <= {mc_r[PW-2:0], 1'b0};
      per_r <= {1'b0, per_r[PER_W-1:1]};
    end
  end

  // floor of the scaled index plus the waveform start
  assign fit_time = p_r[PW-1:FRAC_BITS] + TIME_W'(start_r);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (phase_r)
        PH_READY: begin
          time_r   <= fit_time;
          index_r  <= cpos_r;
          status_r <= STAT_OK;
        end
        PH_NEED_AFTER: begin
          time_r   <= '0;
          index_r  <= cpos_r;
          status_r <= STAT_AT_LAST;
        end
        PH_AT_FIRST: begin
          time_r   <= '0;
          index_r  <= '0;
          status_r <= STAT_AT_FIRST;
        end
        default: begin
          time_r   <= '0;
          index_r  <= '0;
          status_r <= STAT_NO_CROSS;
        end
      endcase
    end
  end

  assign out_time     = time_r;
  assign out_index    = index_r;
  assign out_status   = status_r;
  assign sts.phase    = phase_r;
  assign sts.div_done = div_done;
  assign sts.scl_done = scl_done_r;

endmodule

FILE: hdl/tctp_ctrl.sv
// controller: sample intake, fit sequence and result handshake
module tctp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  tctp_pkg::dp_sts_t sts,
  output tctp_pkg::dp_cmd_t cmd
);
  import tctp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_COLLECT:  if (in_tvalid && in_tlast) state_nxt = S_EVAL;
      S_EVAL:     state_nxt = (sts.phase == PH_READY) ? S_DIFF : S_EMIT;
      S_DIFF:     state_nxt = S_SQ0;
      S_SQ0:      state_nxt = S_SQ1;
      S_SQ1:      state_nxt = S_SQ2;
      S_SQ2:      state_nxt = S_XP;
      S_XP:       state_nxt = S_IDX;
      S_IDX:      state_nxt = S_SUM;
      S_SUM:      state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (sts.div_done) state_nxt = S_SCL_GO;
      S_SCL_GO:   state_nxt = S_SCL_WAIT;
      S_SCL_WAIT: if (sts.scl_done) state_nxt = S_EMIT;
      S_EMIT:     if (out_free) state_nxt = S_COLLECT;
      default:    state_nxt = S_COLLECT;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_COLLECT: begin
        in_tready     = 1'b1;
        cmd.sample_en = in_tvalid;
      end
      S_DIFF: cmd.diff_en = 1'b1;
      S_SQ0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ01;
      end
      S_SQ1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ12;
        cmd.acc_op  = ACC_LOAD;
      end
      S_SQ2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ02;
        cmd.acc_op  = ACC_ADD;
      end
      S_XP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_XP;
        cmd.acc_op  = ACC_ADD;
      end
      S_IDX: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_IDX;
        cmd.acc_op   = ACC_LOAD;
        cmd.den_load = 1'b1;
      end
      S_SUM:    cmd.acc_op    = ACC_ADD;
      S_DIV_GO: cmd.div_start = 1'b1;
      S_SCL_GO: cmd.scl_start = 1'b1;
      S_EMIT:   cmd.out_load  = out_free;
      default:  cmd = '0;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // result register is never overwritten while its transaction is pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten before transfer");

  // a loaded result is offered on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not offered");

  // divider completion only arrives while waiting for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIV_WAIT))
    else $error("divider done outside its wait state");

  // scaler completion only arrives while waiting for it
  a_scl_done: assert property (@(posedge clk) disable iff (!rst_n)
    sts.scl_done |-> (state_r == S_SCL_WAIT))
    else $error("scaler done outside its wait state");

endmodule
